### hw/rtl/ccpd_pkg.sv
package ccpd_pkg;

	localparam int NUM_CHANNELS = 16;
	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	localparam int SCALE_W  = 15;
	localparam int CREDIT_W = 8;
	localparam int PROD_W   = SCALE_W + CREDIT_W;
	localparam int AMOUNT_W = 32;
	localparam int STATUS_W = 3;
	localparam int ERROR_W  = 5;

	typedef enum logic [1:0] {
		FN_START = 2'd0,
		FN_BYTE  = 2'd1,
		FN_LOAD  = 2'd2,
		FN_CLEAR = 2'd3
	} func_t;

	// status codes carried in the low nibble of a status byte
	localparam logic [3:0] ST_PAYBACK  = 4'h1;
	localparam logic [3:0] ST_BUSY     = 4'h2;
	localparam logic [3:0] ST_SENSOR   = 4'h4;
	localparam logic [3:0] ST_TUBE_JAM = 4'h7;
	localparam logic [3:0] ST_ROM      = 4'h8;
	localparam logic [3:0] ST_ROUTING  = 4'h9;
	localparam logic [3:0] ST_BUSY_ALT = 4'hA;
	localparam logic [3:0] ST_RESET    = 4'hB;
	localparam logic [3:0] ST_COIN_JAM = 4'hC;

	// flag bit positions
	localparam int SB_PAYBACK  = 0;
	localparam int SB_BUSY     = 1;
	localparam int SB_RESET    = 2;
	localparam int EB_SENSOR   = 0;
	localparam int EB_TUBE_JAM = 1;
	localparam int EB_ROM      = 2;
	localparam int EB_ROUTING  = 3;
	localparam int EB_COIN_JAM = 4;

	typedef struct packed {
		logic                add_en;
		logic                clear_amt;
		logic [STATUS_W-1:0] status;
		logic [ERROR_W-1:0]  error;
	} dec_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ERROR_W-1:0]  error;
		logic [AMOUNT_W-1:0] amount;
	} res_t;

endpackage

### hw/rtl/ccpd_if.sv
interface ccpd_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] data_byte;
	logic [3:0] channel_index;
	logic [7:0] channel_credit;

	modport source (output valid, func, data_byte, channel_index, channel_credit, input ready);
	modport sink (input valid, func, data_byte, channel_index, channel_credit, output ready);
endinterface

interface ccpd_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status_flags;
	logic [4:0]  error_flags;
	logic [31:0] received_amount;

	modport source (output valid, status_flags, error_flags, received_amount, input ready);
	modport sink (input valid, status_flags, error_flags, received_amount, output ready);
endinterface

interface ccpd_cfg_if;
	logic        valid;
	logic        ready;
	logic [14:0] coin_scale;

	modport source (output valid, coin_scale, input ready);
	modport sink (input valid, coin_scale, output ready);
endinterface

### hw/rtl/ccpd_credit_mem.sv
module ccpd_credit_mem
	import ccpd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [CH_W-1:0]     wr_addr,
	input  logic [CREDIT_W-1:0] wr_data,
	input  logic                rd_en,
	input  logic [CH_W-1:0]     rd_addr,
	output logic [CREDIT_W-1:0] rd_data
);

	logic [CREDIT_W-1:0]     mem [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] vld_q;
	logic [CREDIT_W-1:0]     rd_raw_q;
	logic                    rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_q <= mem[rd_addr];
		end
	end

	// entries never loaded since reset read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_raw_q : '0;

endmodule

### hw/rtl/ccpd_decode.sv
module ccpd_decode
	import ccpd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  func_t      func,
	input  logic [7:0] data_byte,
	output dec_t       dec
);

	logic                skip_q;
	logic [STATUS_W-1:0] status_q;
	logic [ERROR_W-1:0]  error_q;
	logic                skip_nxt;

	always_comb begin
		skip_nxt      = skip_q;
		dec.add_en    = 1'b0;
		dec.clear_amt = 1'b0;
		dec.status    = status_q;
		dec.error     = error_q;
		unique case (func)
			FN_START: begin
				skip_nxt   = 1'b0;
				dec.status = '0;
				dec.error  = '0;
			end
			FN_BYTE: begin
				if (skip_q) begin
					skip_nxt = 1'b0;
				end else if (data_byte[7]) begin
					skip_nxt = 1'b1;
				end else if (data_byte[6]) begin
					// deposit: only tube or cashbox routing adds credit
					skip_nxt   = 1'b1;
					dec.add_en = !data_byte[5] &&
						({1'b0, data_byte[3:0]} < 5'(NUM_CHANNELS));
				end else if (!data_byte[5]) begin
					unique case (data_byte[3:0]) inside
						ST_PAYBACK:           dec.status[SB_PAYBACK]  = 1'b1;
						ST_BUSY, ST_BUSY_ALT: dec.status[SB_BUSY]     = 1'b1;
						ST_RESET:             dec.status[SB_RESET]    = 1'b1;
						ST_SENSOR:            dec.error[EB_SENSOR]    = 1'b1;
						ST_TUBE_JAM:          dec.error[EB_TUBE_JAM]  = 1'b1;
						ST_ROM:               dec.error[EB_ROM]       = 1'b1;
						ST_ROUTING:           dec.error[EB_ROUTING]   = 1'b1;
						ST_COIN_JAM:          dec.error[EB_COIN_JAM]  = 1'b1;
						default: ;
					endcase
				end
			end
			FN_LOAD: ;
			FN_CLEAR: dec.clear_amt = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q   <= 1'b0;
			status_q <= '0;
			error_q  <= '0;
		end else if (step) begin
			skip_q   <= skip_nxt;
			status_q <= dec.status;
			error_q  <= dec.error;
		end
	end

endmodule

### hw/rtl/ccpd_accum.sv
module ccpd_accum
	import ccpd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  dec_t                dec,
	input  logic [CREDIT_W-1:0] credit,
	input  logic [SCALE_W-1:0]  scale,
	input  logic                step,
	output res_t                res
);

	logic [PROD_W-1:0]   prod_s2;
	dec_t                dec_s2;
	logic [AMOUNT_W-1:0] amount_q;
	logic [AMOUNT_W-1:0] amount_nxt;

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s2 <= PROD_W'(credit) * PROD_W'(scale);
			dec_s2  <= dec;
		end
	end

	always_comb begin
		if (dec_s2.clear_amt) begin
			amount_nxt = '0;
		end else if (dec_s2.add_en) begin
			amount_nxt = amount_q + AMOUNT_W'(prod_s2);
		end else begin
			amount_nxt = amount_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amount_q <= '0;
		end else if (step) begin
			amount_q <= amount_nxt;
		end
	end

	assign res.status = dec_s2.status;
	assign res.error  = dec_s2.error;
	assign res.amount = amount_nxt;

endmodule

### hw/rtl/coin_changer_poll_decoder.sv
// channel | dir | payload
// cfg     | in  | coin_scale (15b), written whenever valid, ready tied high
// cmd     | in  | func, data_byte, channel_index, channel_credit
// rsp     | out | status_flags, error_flags, received_amount
//
// One command per cycle sustained while rsp is not stalled; a result is offered
// after acceptance (credit RAM read, multiply register, output register).
// Credit table is a 16-entry synchronous RAM with per-entry valid bits,
// so no clearing pass is needed after reset.
// Stages advance independently; cmd.ready drops only when all stages are full
// and rsp is stalled.
module coin_changer_poll_decoder
	import ccpd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	ccpd_cfg_if.sink    cfg,
	ccpd_cmd_if.sink    cmd,
	ccpd_rsp_if.source  rsp
);

	logic [SCALE_W-1:0] scale_q;
	logic               v1_q;
	logic               v2_q;
	logic               vo_q;
	logic               adv1;
	logic               adv2;
	logic               acc;
	logic               step1;
	logic               step2;
	func_t              func_s1;
	logic [7:0]         data_s1;
	logic [CREDIT_W-1:0] credit;
	logic               wr_en;
	dec_t               dec;
	res_t               res;
	res_t               out_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= '0;
		end else if (cfg.valid) begin
			scale_q <= cfg.coin_scale;
		end
	end

	assign adv2      = !vo_q || rsp.ready;
	assign adv1      = !v2_q || adv2;
	assign cmd.ready = !v1_q || adv1;
	assign acc       = cmd.valid && cmd.ready;
	assign step1     = v1_q && adv1;
	assign step2     = v2_q && adv2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (cmd.ready) begin
				v1_q <= cmd.valid;
			end
			if (adv1) begin
				v2_q <= v1_q;
			end
			if (adv2) begin
				vo_q <= v2_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			func_s1 <= func_t'(cmd.func);
			data_s1 <= cmd.data_byte;
		end
		if (step2) begin
			out_q <= res;
		end
	end

	// write and lookup happen at acceptance, so a load is seen by the next item
	assign wr_en = acc && (func_t'(cmd.func) == FN_LOAD) &&
		({1'b0, cmd.channel_index} < 5'(NUM_CHANNELS));

	ccpd_credit_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (cmd.channel_index[CH_W-1:0]),
		.wr_data (cmd.channel_credit),
		.rd_en   (acc),
		.rd_addr (cmd.data_byte[CH_W-1:0]),
		.rd_data (credit)
	);

	ccpd_decode u_dec (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step1),
		.func      (func_s1),
		.data_byte (data_s1),
		.dec       (dec)
	);

	ccpd_accum u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (step1),
		.dec    (dec),
		.credit (credit),
		.scale  (scale_q),
		.step   (step2),
		.res    (res)
	);

	assign rsp.valid           = vo_q;
	assign rsp.status_flags    = out_q.status;
	assign rsp.error_flags     = out_q.error;
	assign rsp.received_amount = out_q.amount;

`ifndef SYNTHESIS
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v1_q |-> cmd.ready)
		else $error("cmd stalled with empty first stage");

	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		step1 |=> v2_q)
		else $error("transaction lost between stage 1 and stage 2");

	a_s2_moves: assert property (@(posedge clk) disable iff (!arst_n)
		step2 |=> vo_q)
		else $error("transaction lost before output register");

	a_no_rw_load: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> acc)
		else $error("credit write without accepted load");
`endif

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
	import ccpd_pkg::*;

	localparam int LONG_HOLD = 80;

	logic clk = 1'b0;
	logic arst_n;

	ccpd_cfg_if cfg_ch ();
	ccpd_cmd_if cmd_ch ();
	ccpd_rsp_if rsp_ch ();

	coin_changer_poll_decoder uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	always #5 clk = ~clk;

	// shadow copy of the changer state
	logic [CREDIT_W-1:0] credit_shadow [NUM_CHANNELS];
	logic                skip_shadow;
	logic [STATUS_W-1:0] status_shadow;
	logic [ERROR_W-1:0]  error_shadow;
	logic [AMOUNT_W-1:0] amount_shadow;
	logic [SCALE_W-1:0]  scale_shadow;

	res_t due_readings [$];
	int   cmds_sent   = 0;
	int   fault_count = 0;
	int   hold_reqs   = 0;
	bit   pace_gaps   = 1'b1;

	function automatic void note_failure(string msg);
		fault_count++;
		if (fault_count <= 10) begin
			$display("mismatch at %0t: %s", $time, msg);
		end
	endfunction

	function automatic int pick_gap();
		int r;
		if (!pace_gaps) begin
			return 0;
		end
		r = $urandom_range(99);
		if (r < 55) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// advance the shadow state by one command, return the reading it should produce
	function automatic res_t apply_poll_item(func_t f, logic [7:0] b, logic [3:0] ch,
			logic [7:0] cr);
		res_t r;
		case (f)
			FN_START: begin
				status_shadow = '0;
				error_shadow  = '0;
				skip_shadow   = 1'b0;
			end
			FN_BYTE: begin
				if (skip_shadow) begin
					skip_shadow = 1'b0;
				end else if (b[7]) begin
					skip_shadow = 1'b1;
				end else if (b[6]) begin
					skip_shadow = 1'b1;
					// routing 0 or 1 means bit 5 clear; the total wraps at 32 bits
					if (!b[5] && int'(b[3:0]) < NUM_CHANNELS) begin
						amount_shadow = amount_shadow
							+ AMOUNT_W'(credit_shadow[b[3:0]]) * AMOUNT_W'(scale_shadow);
					end
				end else if (!b[5]) begin
					case (b[3:0])
						ST_PAYBACK:            status_shadow[SB_PAYBACK] = 1'b1;
						ST_BUSY, ST_BUSY_ALT:  status_shadow[SB_BUSY]    = 1'b1;
						ST_RESET:              status_shadow[SB_RESET]   = 1'b1;
						ST_SENSOR:             error_shadow[EB_SENSOR]   = 1'b1;
						ST_TUBE_JAM:           error_shadow[EB_TUBE_JAM] = 1'b1;
						ST_ROM:                error_shadow[EB_ROM]      = 1'b1;
						ST_ROUTING:            error_shadow[EB_ROUTING]  = 1'b1;
						ST_COIN_JAM:           error_shadow[EB_COIN_JAM] = 1'b1;
						default: ;
					endcase
				end
			end
			FN_LOAD: begin
				if (int'(ch) < NUM_CHANNELS) begin
					credit_shadow[ch] = cr;
				end
			end
			default: amount_shadow = '0;
		endcase
		r.status = status_shadow;
		r.error  = error_shadow;
		r.amount = amount_shadow;
		return r;
	endfunction

	task automatic send_item(func_t f, logic [7:0] b, logic [3:0] ch, logic [7:0] cr);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid          <= 1'b1;
		cmd_ch.func           <= f;
		cmd_ch.data_byte      <= b;
		cmd_ch.channel_index  <= ch;
		cmd_ch.channel_credit <= cr;
		do @(posedge clk); while (!cmd_ch.ready);
		due_readings.push_back(apply_poll_item(f, b, ch, cr));
		cmds_sent++;
	endtask

	task automatic send_byte(logic [7:0] b);
		send_item(FN_BYTE, b, 4'($urandom), 8'($urandom));
	endtask

	task automatic wait_quiet();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (due_readings.size() != 0) @(posedge clk);
	endtask

	task automatic set_coin_scale(logic [SCALE_W-1:0] v);
		wait_quiet();
		cfg_ch.valid      <= 1'b1;
		cfg_ch.coin_scale <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		scale_shadow = v;
		cfg_ch.valid <= 1'b0;
	endtask

	// well-formed poll replies with random content, plus some noise
	task automatic run_poll_traffic(int n);
		int stop;
		int r;
		logic [7:0] b;
		stop = cmds_sent + n;
		while (cmds_sent < stop) begin
			r = $urandom_range(99);
			b = 8'($urandom);
			if (r < 7) begin
				send_item(FN_START, b, 4'($urandom), 8'($urandom));
			end else if (r < 15) begin
				send_item(FN_LOAD, b, 4'($urandom),
					($urandom_range(3) == 0) ? 8'hFF : 8'($urandom));
			end else if (r < 18) begin
				send_item(FN_CLEAR, b, 4'($urandom), 8'($urandom));
			end else if (r < 23) begin
				send_item(func_t'($urandom_range(3)), b, 4'($urandom), 8'($urandom));
			end else if (r < 45) begin
				b[7:6] = 2'b01;
				b[5:4] = ($urandom_range(3) == 0) ? 2'($urandom) : {1'b0, 1'($urandom)};
				send_byte(b);
				send_byte(8'($urandom));
			end else if (r < 55) begin
				b[7] = 1'b1;
				send_byte(b);
				send_byte(8'($urandom));
			end else if (r < 60) begin
				b[7:5] = 3'b001;
				send_byte(b);
			end else begin
				b[7:5] = 3'b000;
				send_byte(b);
			end
		end
	endtask

	task automatic test_status_codes();
		logic [3:0] codes [8] = '{ST_PAYBACK, ST_BUSY, ST_BUSY_ALT, ST_RESET,
			ST_SENSOR, ST_TUBE_JAM, ST_ROM, ST_ROUTING};
		set_coin_scale(15'd100);
		send_byte(8'h00);
		foreach (codes[i]) begin
			send_byte({4'h0, codes[i]});
		end
		// bit 4 set decodes as the low nibble
		send_byte({4'h1, ST_COIN_JAM});
		send_byte(8'h1F);
		send_item(FN_START, 8'hFF, 4'hF, 8'hFF);
	endtask

	task automatic test_events_and_skip();
		send_item(FN_LOAD, 8'hFF, 4'd15, 8'hFF);
		send_item(FN_LOAD, 8'h00, 4'd0, 8'd1);
		send_byte(8'h40);
		send_byte({4'h0, ST_PAYBACK});
		send_byte(8'h5F);
		send_byte(8'hFF);
		// routed elsewhere: no credit, still skips
		send_byte(8'h6F);
		send_byte({4'h0, ST_COIN_JAM});
		send_byte(8'h80);
		send_byte({4'h0, ST_RESET});
		send_byte(8'h3F);
		// start of reply drops a pending skip
		send_byte(8'hC0);
		send_item(FN_START, 8'h00, 4'h0, 8'h00);
		send_byte({4'h0, ST_BUSY});
		send_item(FN_CLEAR, 8'hFF, 4'hF, 8'hFF);
	endtask

	// largest credits at a scale of 25500 push the total high into 32 bits
	task automatic test_large_amount();
		set_coin_scale(15'd25500);
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			send_item(FN_LOAD, 8'($urandom), 4'(c), 8'hFF);
		end
		repeat (300) begin
			send_byte({2'b01, 1'b0, 1'($urandom), 4'($urandom)});
			send_byte(8'($urandom));
		end
	endtask

	task automatic test_zero_scale();
		set_coin_scale(15'd0);
		pace_gaps = 1'b0;
		run_poll_traffic(80);
		pace_gaps = 1'b1;
	endtask

	task automatic test_unit_scale();
		set_coin_scale(15'd1);
		run_poll_traffic(80);
	endtask

	task automatic test_random_scales();
		repeat (2) begin
			set_coin_scale(15'($urandom_range(2, 25499)));
			run_poll_traffic(100);
		end
	endtask

	task automatic test_backpressure();
		wait_quiet();
		pace_gaps = 1'b0;
		hold_reqs <= hold_reqs + 1;
		run_poll_traffic(48);
		pace_gaps = 1'b1;
	endtask

	// result side: random ready, long hold on request
	initial begin : rsp_pacing
		int idle_left;
		int hold_left;
		int hold_seen;
		idle_left = 0;
		hold_left = 0;
		hold_seen = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_reqs != hold_seen) begin
				hold_seen = hold_reqs;
				hold_left = LONG_HOLD;
			end
			if (!arst_n) begin
				rsp_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (idle_left > 0) begin
				idle_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				idle_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (due_readings.size() == 0) begin
				note_failure($sformatf("unexpected transaction st=%h er=%h amt=%h",
					rsp_ch.status_flags, rsp_ch.error_flags, rsp_ch.received_amount));
			end else begin
				want = due_readings.pop_front();
				if (rsp_ch.status_flags !== want.status) begin
					note_failure($sformatf("status_flags exp %h got %h",
						want.status, rsp_ch.status_flags));
				end
				if (rsp_ch.error_flags !== want.error) begin
					note_failure($sformatf("error_flags exp %h got %h",
						want.error, rsp_ch.error_flags));
				end
				if (rsp_ch.received_amount !== want.amount) begin
					note_failure($sformatf("received_amount exp %h got %h",
						want.amount, rsp_ch.received_amount));
				end
			end
		end
	end

	initial begin
		#6_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		arst_n                <= 1'b0;
		cmd_ch.valid          <= 1'b0;
		cmd_ch.func           <= FN_START;
		cmd_ch.data_byte      <= '0;
		cmd_ch.channel_index  <= '0;
		cmd_ch.channel_credit <= '0;
		cfg_ch.valid          <= 1'b0;
		cfg_ch.coin_scale     <= '0;
		foreach (credit_shadow[i]) begin
			credit_shadow[i] = '0;
		end
		skip_shadow    = 1'b0;
		status_shadow  = '0;
		error_shadow   = '0;
		amount_shadow  = '0;
		scale_shadow   = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_status_codes();
		test_events_and_skip();
		test_large_amount();
		test_zero_scale();
		test_unit_scale();
		test_random_scales();
		test_backpressure();

		cmd_ch.valid <= 1'b0;
		for (int i = 0; i < 2000 && due_readings.size() != 0; i++) @(posedge clk);
		repeat (8) @(posedge clk);
		if (due_readings.size() != 0) begin
			note_failure($sformatf("%0d readings never arrived", due_readings.size()));
		end
		if (fault_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
